// ===== rtl/core/bloom_filter_string_set_assert.svh =====
// ----------------------------------------------------------------------------
// Bloom filter string set: assertion macros
// Clocked property checks; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_STRING_SET_ASSERT_SVH
`define BLOOM_FILTER_STRING_SET_ASSERT_SVH
`ifndef SYNTH
// check a property on every clock edge outside reset
`define BFSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check a property on every clock edge, reset included
`define BFSS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BFSS_ASSERT(lbl, prop, msg)
`define BFSS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/bfss_pkg.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string set: package
// Controller states, datapath command and status bundles, register map.
// ----------------------------------------------------------------------------
package bfss_pkg;

  // largest value the table_size register can hold
  localparam int unsigned TABLE_SIZE_MAX = 131071;

  // register map (word index, byte address bit 2)
  localparam logic REG_HASH_COUNT = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  localparam logic [3:0]  HASH_COUNT_RST = 4'd7;
  localparam logic [16:0] TABLE_SIZE_RST = 17'd65536;

  // result status codes
  localparam logic [1:0] STAT_ABSENT  = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD_CHAR,
    ST_END,
    ST_MOD_POS,
    ST_CHK_RD,
    ST_CHK_TEST,
    ST_SET_RD,
    ST_SET_WR
  } state_e;

  typedef struct packed {
    logic       cap_item;
    logic       load_char;
    logic       load_pos;
    logic       step;
    logic       save_hash;
    logic       clear_str;
    logic       clr_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       mem_rd;
    logic       mem_wr;
    logic       emit;
    logic [1:0] emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic add;
    logic last;
    logic seen;
    logic step_last;
    logic idx_last;
    logic bit_set;
    logic clr_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/bfss_cfg.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string set: configuration registers
// APB register file for hash_count and table_size, with range clamping.
// ----------------------------------------------------------------------------
module bfss_cfg #(
  parameter int unsigned MAX_HASHES = 8,
  parameter int unsigned MAP_BITS   = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [$clog2(MAX_HASHES+1)-1:0]                          hash_num_o,
  output logic [$clog2(((MAP_BITS < 131071) ? MAP_BITS : 131071)+1)-1:0] modulus_o
);
  import bfss_pkg::*;

  localparam int unsigned MOD_MAX = (MAP_BITS < TABLE_SIZE_MAX) ? MAP_BITS : TABLE_SIZE_MAX;
  localparam int unsigned K_W     = $clog2(MAX_HASHES + 1);
  localparam int unsigned M_W     = $clog2(MOD_MAX + 1);

  logic [3:0]  hash_count_q;
  logic [16:0] table_size_q;
  logic        wr_en;
  logic [4:0]  hc_ext;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // write registers on the access phase of a write transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_count_q <= HASH_COUNT_RST;
      table_size_q <= TABLE_SIZE_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_HASH_COUNT) begin
        hash_count_q <= pwdata[3:0];
      end else begin
        table_size_q <= pwdata[16:0];
      end
    end
  end

  // read back raw register values
  always_comb begin
    if (paddr[2] == REG_HASH_COUNT) begin
      prdata = {28'd0, hash_count_q};
    end else begin
      prdata = {15'd0, table_size_q};
    end
  end

  // clamp hash count into 1..MAX_HASHES
  assign hc_ext = {1'b0, hash_count_q};
  always_comb begin
    if (hash_count_q == 4'd0) begin
      hash_num_o = K_W'(1);
    end else if (hc_ext > 5'(MAX_HASHES)) begin
      hash_num_o = K_W'(MAX_HASHES);
    end else begin
      hash_num_o = K_W'(hash_count_q);
    end
  end

  // clamp modulus into 2..MOD_MAX
  always_comb begin
    if (table_size_q < 17'd2) begin
      modulus_o = M_W'(2);
    end else if (table_size_q > 17'(MOD_MAX)) begin
      modulus_o = M_W'(MOD_MAX);
    end else begin
      modulus_o = M_W'(table_size_q);
    end
  end

endmodule

// ===== rtl/core/bfss_dp.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string set: datapath
// Hash lanes with bit-serial remainder units, step and index counters,
// bit store memory with clearing sweep, result registers.
// ----------------------------------------------------------------------------
module bfss_dp #(
  parameter int unsigned MAX_HASHES = 8,
  parameter int unsigned MAP_BITS   = 65536,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   operation_i,
  input  logic [7:0]             char_byte_i,
  input  logic                   last_char_i,
  input  logic [$clog2(MAX_HASHES+1)-1:0]                          hash_num_i,
  input  logic [$clog2(((MAP_BITS < 131071) ? MAP_BITS : 131071)+1)-1:0] modulus_i,
  input  bfss_pkg::dp_cmd_t      cmd_i,
  output bfss_pkg::dp_stat_t     stat_o,
  output logic [1:0]             status_o,
  output logic                   was_add_o
);
  import bfss_pkg::*;

  localparam int unsigned MOD_MAX = (MAP_BITS < TABLE_SIZE_MAX) ? MAP_BITS : TABLE_SIZE_MAX;
  localparam int unsigned K_W     = $clog2(MAX_HASHES + 1);
  localparam int unsigned M_W     = $clog2(MOD_MAX + 1);
  localparam int unsigned HASH_W  = $clog2(MOD_MAX);
  localparam int unsigned RX_W    = HASH_W + 1;
  localparam int unsigned SEED_W  = $clog2(MAX_HASHES * MAX_HASHES + 2);
  localparam int unsigned XW      = HASH_W + SEED_W + 1;
  localparam int unsigned STEP_W  = $clog2(XW);
  localparam int unsigned DEPTH   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFF_W   = $clog2(WORD_BITS);
  localparam int unsigned IX_W    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

  logic [HASH_W-1:0] h_q [MAX_HASHES];
  logic [XW-1:0]     x_q [MAX_HASHES];
  logic [HASH_W-1:0] r_q [MAX_HASHES];

  logic [RX_W-1:0]    divisor;
  logic [STEP_W-1:0]  cnt_q;
  logic [IX_W-1:0]    idx_q;
  logic [IDX_W-1:0]   clr_q;
  logic               seen_q;
  logic               op_q;
  logic               last_q;
  logic [1:0]         status_q;
  logic               was_add_q;

  logic [HASH_W-1:0]    sel_r;
  logic [IDX_W-1:0]     sel_word;
  logic [OFF_W-1:0]     sel_off;
  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  // divide by the modulus
  assign divisor = RX_W'(modulus_i);

  // hash lanes: one restoring remainder step per cycle
  for (genvar g = 0; g < MAX_HASHES; g++) begin : g_lane
    localparam int unsigned SEED = (g + 1) * (g + 1) + 1;

    logic [RX_W-1:0]   rx;
    logic [RX_W-1:0]   rsub;
    logic              ge;
    logic [HASH_W-1:0] r_nx;
    logic [XW-1:0]     x_nx;
    logic [XW-1:0]     x_mul;

    assign rx    = {r_q[g], x_q[g][XW-1]};
    assign ge    = (rx >= divisor);
    assign rsub  = rx - divisor;
    assign r_nx  = ge ? rsub[HASH_W-1:0] : rx[HASH_W-1:0];
    assign x_nx  = {x_q[g][XW-2:0], ge};
    assign x_mul = XW'(SEED) * XW'(h_q[g]) + XW'(char_byte_i);

    // running hash, cleared at reset and at string end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        h_q[g] <= '0;
      end else if (cmd_i.clear_str) begin
        h_q[g] <= '0;
      end else if (cmd_i.save_hash) begin
        h_q[g] <= r_nx;
      end
    end

    // dividend shifter and partial remainder
    always_ff @(posedge clk_i) begin
      if (cmd_i.load_char) begin
        x_q[g] <= x_mul;
        r_q[g] <= '0;
      end else if (cmd_i.load_pos) begin
        x_q[g] <= XW'(h_q[g]);
        r_q[g] <= '0;
      end else if (cmd_i.step) begin
        x_q[g] <= x_nx;
        r_q[g] <= r_nx;
      end
    end
  end

  // step counter, restarted by every load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_char || cmd_i.load_pos) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + STEP_W'(1);
    end
  end

  // hash index for the bit store walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IX_W'(1);
    end
  end

  // clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // string flags and captured item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      op_q   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.cap_item) begin
        op_q   <= operation_i;
        last_q <= last_char_i;
      end
      if (cmd_i.clear_str) begin
        seen_q <= 1'b0;
      end else if (cmd_i.save_hash) begin
        seen_q <= 1'b1;
      end
    end
  end

  // selected lane: word index and bit offset are slices of the reduced position
  assign sel_r    = r_q[idx_q];
  assign sel_word = IDX_W'(sel_r >> OFF_W);
  assign sel_off  = sel_r[OFF_W-1:0];

  // bit store write port: sweep zeros or set one bit
  assign mem_we = cmd_i.clr_wr | cmd_i.mem_wr;
  assign mem_wa = cmd_i.clr_wr ? clr_q : sel_word;
  assign mem_wd = cmd_i.clr_wr ? '0 : (rd_q | (WORD_BITS'(1) << sel_off));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[sel_word];
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q  <= cmd_i.emit_status;
      was_add_q <= op_q;
    end
  end

  assign status_o  = status_q;
  assign was_add_o = was_add_q;

  // status toward the controller
  always_comb begin
    stat_o           = '0;
    stat_o.add       = op_q;
    stat_o.last      = last_q;
    stat_o.seen      = seen_q;
    stat_o.step_last = (cnt_q == STEP_W'(XW - 1));
    stat_o.idx_last  = ((K_W'(idx_q) + K_W'(1)) == hash_num_i);
    stat_o.bit_set   = rd_q[sel_off];
    stat_o.clr_last  = (clr_q == IDX_W'(DEPTH - 1));
  end

endmodule

// ===== rtl/core/bfss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string set: controller
// Sequences the clearing sweep, per-character hashing, position reduction,
// bit store test and set, and issues the result strobe.
// ----------------------------------------------------------------------------
module bfss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                char_valid_i,
  input  logic                last_char_i,
  input  bfss_pkg::dp_stat_t  stat_i,
  output bfss_pkg::dp_cmd_t   cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import bfss_pkg::*;

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.emit;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          if (char_valid_i) begin
            state_d = ST_MOD_CHAR;
          end else if (last_char_i) begin
            state_d = ST_END;
          end
        end
      end
      ST_MOD_CHAR: begin
        if (stat_i.step_last) state_d = stat_i.last ? ST_END : ST_IDLE;
      end
      ST_END: begin
        state_d = stat_i.seen ? ST_MOD_POS : ST_IDLE;
      end
      ST_MOD_POS: begin
        if (stat_i.step_last) state_d = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        state_d = ST_CHK_TEST;
      end
      ST_CHK_TEST: begin
        if (!stat_i.bit_set) begin
          state_d = stat_i.add ? ST_SET_RD : ST_IDLE;
        end else begin
          state_d = stat_i.idx_last ? ST_IDLE : ST_CHK_RD;
        end
      end
      ST_SET_RD: begin
        state_d = ST_SET_WR;
      end
      ST_SET_WR: begin
        state_d = stat_i.idx_last ? ST_IDLE : ST_SET_RD;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.cap_item  = start_i;
        cmd_o.load_char = start_i & char_valid_i;
      end
      ST_MOD_CHAR: begin
        cmd_o.step      = 1'b1;
        cmd_o.save_hash = stat_i.step_last;
      end
      ST_END: begin
        if (stat_i.seen) begin
          cmd_o.load_pos = 1'b1;
        end else begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = STAT_EMPTY;
          cmd_o.clear_str   = 1'b1;
        end
      end
      ST_MOD_POS: begin
        cmd_o.step    = 1'b1;
        cmd_o.idx_clr = stat_i.step_last;
      end
      ST_CHK_RD: begin
        cmd_o.mem_rd = 1'b1;
      end
      ST_CHK_TEST: begin
        if (!stat_i.bit_set) begin
          if (stat_i.add) begin
            cmd_o.idx_clr = 1'b1;
          end else begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STAT_ABSENT;
            cmd_o.clear_str   = 1'b1;
          end
        end else if (stat_i.idx_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = STAT_PRESENT;
          cmd_o.clear_str   = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SET_RD: begin
        cmd_o.mem_rd = 1'b1;
      end
      ST_SET_WR: begin
        cmd_o.mem_wr = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = STAT_ABSENT;
          cmd_o.clear_str   = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/bloom_filter_string_set.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string set: top level
// Channel    | Handshake                    | Payload
// item in    | start / busy                 | operation_i, char_byte_i,
//            |                              | char_valid_i, last_char_i
// result out | done_o (one-cycle strobe)    | status_o, was_add_o
// config     | APB psel/penable/pwrite      | paddr, pwdata, prdata
//
// A character keeps busy high while every hash lane runs one restoring
// remainder step per cycle over its XW-bit dividend (XW = hash width + seed
// width + 1, 24 with default parameters), all lanes in parallel.
// A string end then reduces the positions by the current table size (word
// index and bit offset are then slices of the position), then tests and
// sets bits hash by hash, with one bit store port doing one read or one
// write at a time.
// After reset a clearing pass writes zero to all MAP_BITS/WORD_BITS words
// with busy high; configuration writes are taken.
// Results cannot be stalled: done_o marks them for exactly one cycle.
// ----------------------------------------------------------------------------
`include "bloom_filter_string_set_assert.svh"

module bloom_filter_string_set #(
  parameter int unsigned MAX_HASHES = 8,
  parameter int unsigned MAP_BITS   = 65536,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [7:0]  char_byte_i,
  input  logic        char_valid_i,
  input  logic        last_char_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        was_add_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfss_pkg::*;

  localparam int unsigned MOD_MAX = (MAP_BITS < TABLE_SIZE_MAX) ? MAP_BITS : TABLE_SIZE_MAX;
  localparam int unsigned K_W     = $clog2(MAX_HASHES + 1);
  localparam int unsigned M_W     = $clog2(MOD_MAX + 1);

  logic [K_W-1:0] hash_num;
  logic [M_W-1:0] modulus;
  dp_cmd_t        cmd;
  dp_stat_t       stat;

  bfss_cfg #(
    .MAX_HASHES (MAX_HASHES),
    .MAP_BITS   (MAP_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .hash_num_o (hash_num),
    .modulus_o  (modulus)
  );

  bfss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .char_valid_i (char_valid_i),
    .last_char_i  (last_char_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .done_o       (done_o)
  );

  bfss_dp #(
    .MAX_HASHES (MAX_HASHES),
    .MAP_BITS   (MAP_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .char_byte_i (char_byte_i),
    .last_char_i (last_char_i),
    .hash_num_i  (hash_num),
    .modulus_i   (modulus),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (status_o),
    .was_add_o   (was_add_o)
  );

  // a result is only issued on the way back to idle
  `BFSS_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  // a character always starts hashing work
  `BFSS_ASSERT(a_char_busy, start && !busy && char_valid_i |=> busy, "character not taken up")
  // no two results in adjacent cycles
  `BFSS_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe held")
  // reset keeps the result strobe quiet
  `BFSS_ASSERT_NR(a_rst_quiet, !rst_ni |=> !done_o, "result strobe after reset")

endmodule

// ===== bench/bloom_filter_string_set_tb.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string set: testbench
// Streams byte strings, one character per transaction, into the filter as
// queries and adds. An in-bench model keeps the running hash lanes and its own
// copy of the bitmap, and predicts each string verdict. A checker compares
// every done_o strobe with the oldest predicted verdict. Directed tests cover
// empty strings, mixed operations, register extremes and a table size change
// inside a string. Random traffic then reuses a small dictionary of strings
// so that both hits and misses occur.
// ----------------------------------------------------------------------------
module bloom_filter_string_set_tb;
  import bfss_pkg::*;

  localparam int unsigned MAX_HASHES   = 8;
  localparam int unsigned MAP_BITS     = 65536;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned MAX_LEN      = 12;
  localparam int unsigned DICT_SIZE    = 24;
  localparam int unsigned SETTLE_WAIT  = 150;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [1:0] status;
    logic       was_add;
  } verdict_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic        operation_i = 1'b0;
  logic [7:0]  char_byte_i = 8'h00;
  logic        char_valid_i = 1'b0;
  logic        last_char_i = 1'b0;
  logic        done_o;
  logic [1:0]  status_o;
  logic        was_add_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'd0;
  logic [31:0] pwdata      = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // filter model: configuration, hash lanes, bitmap
  bit [3:0]    cfg_hash_count = HASH_COUNT_RST;
  bit [16:0]   cfg_table_size = TABLE_SIZE_RST;
  int unsigned hash_lane [MAX_HASHES];
  bit          str_started;
  bit          bitmap [MAP_BITS];
  verdict_t    expected_verdicts [$];

  // string dictionary for random traffic
  bit [7:0]    dict_text [DICT_SIZE][MAX_LEN];
  int unsigned dict_len [DICT_SIZE];

  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned status_tally [3];

  always #2 clk_i = ~clk_i;

  bloom_filter_string_set #(
    .MAX_HASHES(MAX_HASHES),
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .char_byte_i (char_byte_i),
    .char_valid_i(char_valid_i),
    .last_char_i (last_char_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .was_add_o   (was_add_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // advance hash lanes on one character; on a string end test and set bits
  function automatic void hash_and_lookup(input bit add, input bit [7:0] ch,
                                          input bit valid, input bit last);
    int unsigned m;
    int unsigned k;
    int unsigned seed;
    bit          hit;
    verdict_t    v;
    m = (cfg_table_size < 2) ? 2 : ((cfg_table_size > MAP_BITS) ? MAP_BITS : cfg_table_size);
    k = (cfg_hash_count == 0) ? 1 :
        ((cfg_hash_count > MAX_HASHES) ? MAX_HASHES : cfg_hash_count);
    if (valid) begin
      for (int i = 0; i < MAX_HASHES; i++) begin
        seed = (i + 1) * (i + 1) + 1;
        hash_lane[i] = (seed * hash_lane[i] + ch) % m;
      end
      str_started = 1'b1;
    end
    if (!last) return;
    v.was_add = add;
    if (!str_started) begin
      v.status = STAT_EMPTY;
    end else begin
      hit = 1'b1;
      for (int i = 0; i < k; i++) begin
        if (!bitmap[hash_lane[i] % m]) hit = 1'b0;
      end
      if (hit) begin
        v.status = STAT_PRESENT;
      end else begin
        if (add) begin
          for (int i = 0; i < k; i++) bitmap[hash_lane[i] % m] = 1'b1;
        end
        v.status = STAT_ABSENT;
      end
    end
    status_tally[v.status]++;
    expected_verdicts.push_back(v);
    for (int i = 0; i < MAX_HASHES; i++) hash_lane[i] = 0;
    str_started = 1'b0;
  endfunction

  // send one character transaction, with an optional gap in front
  task automatic send_item(input bit add, input bit [7:0] ch, input bit valid, input bit last);
    int unsigned gap;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(90, 20) : $urandom_range(6, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= add;
    char_byte_i  <= ch;
    char_valid_i <= valid;
    last_char_i  <= last;
    do @(posedge clk_i); while (busy);
    hash_and_lookup(add, ch, valid, last);
    if (valid || last) n_items++;
  endtask

  // drop start, wait for outstanding verdicts, then let the block go idle
  task automatic quiesce_block();
    start <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_verdicts.size() != 0; n++) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      n_mismatch += expected_verdicts.size();
      $display("%0d expected results never arrived", expected_verdicts.size());
      expected_verdicts.delete();
    end
    repeat (SETTLE_WAIT) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // write both registers back to back over the APB port
  task automatic write_config(input bit [3:0] hashes, input bit [16:0] tbl_size);
    for (int r = 0; r < 2; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {(r == 0) ? REG_HASH_COUNT : REG_TABLE_SIZE, 2'b00};
      pwdata  <= (r == 0) ? 32'(hashes) : 32'(tbl_size);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (r == 0) cfg_hash_count = hashes;
      else cfg_table_size = tbl_size;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  function automatic void make_word(input int unsigned slot);
    dict_len[slot] = ($urandom_range(19) == 0) ? MAX_LEN : $urandom_range(6, 1);
    for (int j = 0; j < MAX_LEN; j++) dict_text[slot][j] = 8'($urandom_range(255));
  endfunction

  // send a dictionary string; inner characters carry random operations and
  // may be interleaved with ignored markers or closed by an empty marker
  task automatic send_word(input int unsigned slot, input bit add);
    bit end_marker;
    int unsigned len;
    len = dict_len[slot];
    end_marker = ($urandom_range(9) == 0);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(19) == 0) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item((j == len - 1) ? add : 1'($urandom_range(1)), dict_text[slot][j], 1'b1,
                (j == len - 1) && !end_marker);
    end
    if (end_marker) send_item(add, 8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // add and query single characters and one two-character string at the byte extremes, reset settings
  task automatic test_basic_membership();
    sender_idle_pct = 20;
    send_item(1'b1, 8'h00, 1'b1, 1'b1);
    send_item(1'b0, 8'h00, 1'b1, 1'b1);
    send_item(1'b0, 8'hFF, 1'b1, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1, 1'b0);
    send_item(1'b1, 8'h00, 1'b1, 1'b1);
  endtask

  // empty strings, an ignored marker, and a string closed by an empty marker
  task automatic test_empty_strings();
    send_item(1'b0, 8'hAA, 1'b0, 1'b1);
    send_item(1'b1, 8'h55, 1'b0, 1'b1);
    send_item(1'b1, 8'h0F, 1'b0, 1'b0);
    send_item(1'b0, 8'hF0, 1'b0, 1'b1);
    send_item(1'b1, 8'h41, 1'b1, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b1);
  endtask

  // only the operation of the closing transaction counts
  task automatic test_mixed_operations();
    send_item(1'b1, 8'h5A, 1'b1, 1'b0);
    send_item(1'b0, 8'hA5, 1'b1, 1'b1);
    send_item(1'b0, 8'h5A, 1'b1, 1'b0);
    send_item(1'b1, 8'hA5, 1'b1, 1'b1);
  endtask

  // register values at and beyond both ends of their ranges
  task automatic test_register_extremes();
    quiesce_block();
    write_config(4'd0, 17'd0);
    send_item(1'b1, 8'h01, 1'b1, 1'b1);
    send_item(1'b0, 8'h02, 1'b1, 1'b1);
    quiesce_block();
    write_config(4'd15, 17'd131071);
    send_item(1'b1, 8'h7F, 1'b1, 1'b0);
    send_item(1'b1, 8'h80, 1'b1, 1'b1);
    quiesce_block();
    write_config(4'd8, 17'd1);
    send_item(1'b0, 8'h33, 1'b1, 1'b1);
  endtask

  // shrink the table between characters of one string
  task automatic test_table_change_mid_string();
    quiesce_block();
    write_config(4'd7, 17'd65536);
    send_item(1'b1, 8'hC3, 1'b1, 1'b0);
    send_item(1'b1, 8'h3C, 1'b1, 1'b0);
    quiesce_block();
    write_config(4'd7, 17'd100);
    send_item(1'b1, 8'h99, 1'b1, 1'b1);
  endtask

  // random strings from a dictionary, plus new words, empties and noise
  task automatic test_random_strings(input bit [3:0] hashes, input bit [16:0] tbl_size,
                                     input int unsigned idle_pct, input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned slot;
    quiesce_block();
    write_config(hashes, tbl_size);
    sender_idle_pct = idle_pct;
    for (int s = 0; s < DICT_SIZE; s++) make_word(s);
    target = n_items + count;
    while (n_items < target) begin
      pick = $urandom_range(99);
      slot = $urandom_range(DICT_SIZE - 1);
      if (pick < 55) begin
        send_word(slot, 1'($urandom_range(1)));
      end else if (pick < 80) begin
        make_word(slot);
        send_word(slot, $urandom_range(99) < 60);
      end else if (pick < 85) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b1);
      end else begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  // compare each result strobe with the oldest predicted verdict
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_verdicts.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("unexpected result: status %0d was_add %0d", status_o, was_add_o);
        end
      end else begin
        want = expected_verdicts.pop_front();
        if (status_o !== want.status || was_add_o !== want.was_add) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("result %0d: expected status %0d was_add %0d, got status %0d was_add %0d",
                     n_results, want.status, want.was_add, status_o, was_add_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[bloom_filter_string_set] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_membership();
    test_empty_strings();
    test_mixed_operations();
    test_register_extremes();
    test_table_change_mid_string();
    test_random_strings(4'd8, 17'd65536, 20, 150);
    test_random_strings(4'd3, 17'd1000, 20, 150);
    test_random_strings(4'd1, 17'd2, 51, 150);
    test_random_strings(4'd5, 17'($urandom_range(4096, 64)), 51, 150);
    test_random_strings(4'($urandom_range(8, 1)), 17'($urandom_range(65536, 2)), 0, 150);
    test_random_strings(4'd4, 17'd300, 0, 150);
    quiesce_block();
    $display("covered %0d transactions, %0d results (%0d absent/added, %0d present, %0d empty)",
             n_items, n_results, status_tally[STAT_ABSENT], status_tally[STAT_PRESENT],
             status_tally[STAT_EMPTY]);
    $display("across %0d register settings, %0d mismatches", n_settings, n_mismatch);
    if (n_mismatch == 0) begin
      $display("[bloom_filter_string_set] OK");
    end else begin
      $display("[bloom_filter_string_set] ERROR");
    end
    $finish;
  end

endmodule
